>>> src/ilbc_pkg.sv
package ilbc_pkg;

  localparam logic [2:0] REQ_TICK         = 3'd0;
  localparam logic [2:0] REQ_ACTIVATE_ON  = 3'd1;
  localparam logic [2:0] REQ_ACTIVATE_OFF = 3'd2;
  localparam logic [2:0] REQ_TEMP_ADJUST  = 3'd3;
  localparam logic [2:0] REQ_LIGHT_ADJUST = 3'd4;

  localparam logic [1:0] STATUS_CREATED  = 2'd0;
  localparam logic [1:0] STATUS_BAD_REQ  = 2'd1;
  localparam logic [1:0] STATUS_NO_REPLY = 2'd2;

  localparam int LED_R = 0;
  localparam int LED_G = 1;
  localparam int LED_B = 2;

  localparam logic [2:0] LEDS_RED_ONLY = 3'b001;
  localparam logic [2:0] LED_MASK_FULL = 3'b111;

  localparam logic [8:0] HOLD_MAX = 9'd511;
  localparam logic [8:0] HOLD_ZERO_ADJUST = 9'd1;

  localparam logic [5:0] SAMPLE_INTERVAL_RST = 6'd20;

  localparam logic REG_SAMPLE_INTERVAL = 1'b0;

  typedef struct packed {
    logic       active;
    logic [2:0] leds;
    logic [2:0] mask;
    logic [8:0] green_hold;
    logic [8:0] blue_hold;
    logic [5:0] tick;
  } state_t;

  typedef struct packed {
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic [1:0] status;
    logic       sample_now;
  } res_t;

endpackage

>>> src/ilbc_if.sv
interface ilbc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] adjust_value;

  modport source (output valid, output req_type, output adjust_value, input ready);
  modport sink (input valid, input req_type, input adjust_value, output ready);
endinterface

interface ilbc_out_if;
  logic       valid;
  logic       ready;
  logic       led_red;
  logic       led_green;
  logic       led_blue;
  logic [1:0] status;
  logic       sample_now;

  modport source (output valid, output led_red, output led_green, output led_blue,
                  output status, output sample_now, input ready);
  modport sink (input valid, input led_red, input led_green, input led_blue,
                input status, input sample_now, output ready);
endinterface

>>> src/ilbc_step.sv
module ilbc_step #(
  parameter int ADJUST_FRAC_BITS = 8
) (
  input  ilbc_pkg::state_t   st_cur,
  input  logic [2:0]         req_type,
  input  logic signed [15:0] adjust_value,
  input  logic [5:0]         sample_interval,
  output ilbc_pkg::state_t   st_nxt,
  output ilbc_pkg::res_t     res
);

  logic        neg;
  logic [16:0] mag;
  logic [16:0] part;
  logic [8:0]  adj_cnt;
  logic        adj_led;
  logic        adj_set;

  // adjust decode: magnitude truncated toward zero, doubled and saturated
  always_comb begin
    neg  = adjust_value[15];
    mag  = neg ? (17'h10000 - {1'b0, adjust_value}) : {1'b0, adjust_value};
    part = mag >> ADJUST_FRAC_BITS;
    adj_set = (part != 17'd0);
    adj_led = !neg;
    if (adjust_value == 16'sd0) begin
      adj_cnt = ilbc_pkg::HOLD_ZERO_ADJUST;
    end else if (part > 17'd255) begin
      adj_cnt = ilbc_pkg::HOLD_MAX;
    end else begin
      adj_cnt = {part[7:0], 1'b0};
    end
  end

  always_comb begin
    st_nxt = st_cur;
    res.status = ilbc_pkg::STATUS_BAD_REQ;
    res.sample_now = 1'b0;
    case (req_type)
      ilbc_pkg::REQ_TICK: begin
        res.status = ilbc_pkg::STATUS_NO_REPLY;
        if (st_cur.active) begin
          if (st_cur.tick == sample_interval) begin
            res.sample_now = 1'b1;
            st_nxt.tick = 6'd1;
          end else begin
            st_nxt.tick = st_cur.tick + 6'd1;
          end
          if (st_cur.green_hold != 9'd0) begin
            st_nxt.green_hold = st_cur.green_hold - 9'd1;
            if (st_cur.green_hold == 9'd1) begin
              st_nxt.mask[ilbc_pkg::LED_G] = 1'b1;
              st_nxt.leds[ilbc_pkg::LED_G] = st_cur.leds[ilbc_pkg::LED_R];
            end
          end
          if (st_cur.blue_hold != 9'd0) begin
            st_nxt.blue_hold = st_cur.blue_hold - 9'd1;
            if (st_cur.blue_hold == 9'd1) begin
              st_nxt.mask[ilbc_pkg::LED_B] = 1'b1;
              st_nxt.leds[ilbc_pkg::LED_B] = st_cur.leds[ilbc_pkg::LED_R];
            end
          end
          st_nxt.leds = st_nxt.leds ^ st_nxt.mask;
        end
      end
      ilbc_pkg::REQ_ACTIVATE_ON: begin
        if (!st_cur.active) begin
          st_nxt.active = 1'b1;
          st_nxt.mask = ilbc_pkg::LED_MASK_FULL;
          st_nxt.leds = ilbc_pkg::LED_MASK_FULL;
          res.status = ilbc_pkg::STATUS_CREATED;
        end
      end
      ilbc_pkg::REQ_ACTIVATE_OFF: begin
        if (st_cur.active) begin
          st_nxt.active = 1'b0;
          st_nxt.leds = ilbc_pkg::LEDS_RED_ONLY;
          res.status = ilbc_pkg::STATUS_CREATED;
        end
      end
      ilbc_pkg::REQ_TEMP_ADJUST: begin
        if (adj_set) begin
          st_nxt.leds[ilbc_pkg::LED_G] = adj_led;
        end
        st_nxt.mask[ilbc_pkg::LED_G] = 1'b0;
        st_nxt.green_hold = adj_cnt;
        res.status = ilbc_pkg::STATUS_CREATED;
      end
      ilbc_pkg::REQ_LIGHT_ADJUST: begin
        if (adj_set) begin
          st_nxt.leds[ilbc_pkg::LED_B] = adj_led;
        end
        st_nxt.mask[ilbc_pkg::LED_B] = 1'b0;
        st_nxt.blue_hold = adj_cnt;
        res.status = ilbc_pkg::STATUS_CREATED;
      end
      default: begin
        res.status = ilbc_pkg::STATUS_BAD_REQ;
      end
    endcase
    res.led_red   = st_nxt.leds[ilbc_pkg::LED_R];
    res.led_green = st_nxt.leds[ilbc_pkg::LED_G];
    res.led_blue  = st_nxt.leds[ilbc_pkg::LED_B];
  end

endmodule

>>> src/indicator_led_blink_controller.sv
// an input transfer lands in the input register; its result is then offered from the result register
// throughput: one item per cycle while no result waits, input register feeds a single step into the result register
// a waiting result holds the step; the input register takes one more transfer, then stalls
// reset (synchronous, rst_n low): idle, red on, green and blue off, all blink bits set,
// hold counts and tick count zero, sample_interval 20, both pipeline registers empty
module indicator_led_blink_controller #(
  parameter int ADJUST_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  ilbc_in_if.sink            in_ch,
  ilbc_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic               in_valid_r;
  logic [2:0]         req_type_r;
  logic signed [15:0] adjust_value_r;
  logic               out_valid_r;
  ilbc_pkg::res_t     out_r;
  ilbc_pkg::res_t     res_nxt;
  ilbc_pkg::state_t   state_r;
  ilbc_pkg::state_t   state_nxt;
  logic [5:0]         sample_interval_r;
  logic               advance;
  logic               cfg_wr;

  assign advance = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ilbc_pkg::REG_SAMPLE_INTERVAL);
  assign prdata = (paddr[2] == ilbc_pkg::REG_SAMPLE_INTERVAL) ?
                  {26'd0, sample_interval_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_interval_r <= ilbc_pkg::SAMPLE_INTERVAL_RST;
    end else if (cfg_wr) begin
      sample_interval_r <= pwdata[5:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_type_r     <= in_ch.req_type;
      adjust_value_r <= in_ch.adjust_value;
    end
  end

  ilbc_step #(
    .ADJUST_FRAC_BITS(ADJUST_FRAC_BITS)
  ) u_step (
    .st_cur          (state_r),
    .req_type        (req_type_r),
    .adjust_value    (adjust_value_r),
    .sample_interval (sample_interval_r),
    .st_nxt          (state_nxt),
    .res             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.active     <= 1'b0;
      state_r.leds       <= ilbc_pkg::LEDS_RED_ONLY;
      state_r.mask       <= ilbc_pkg::LED_MASK_FULL;
      state_r.green_hold <= 9'd0;
      state_r.blue_hold  <= 9'd0;
      state_r.tick       <= 6'd0;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.led_red    = out_r.led_red;
  assign out_ch.led_green  = out_r.led_green;
  assign out_ch.led_blue   = out_r.led_blue;
  assign out_ch.status     = out_r.status;
  assign out_ch.sample_now = out_r.sample_now;

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid_r && !in_valid_r)
    else $error("pipeline not empty after reset");

  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && advance |=> out_valid_r)
    else $error("stepped item did not reach result register");

  a_sample_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.sample_now |-> state_r.active && state_r.tick == 6'd1)
    else $error("sample pulse without active restart of tick count");

  a_sample_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.sample_now |-> out_r.status == ilbc_pkg::STATUS_NO_REPLY)
    else $error("sample pulse on a non-tick result");

endmodule
